[hdl/tcpn_pkg.sv]
package tcpn_pkg;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_NORM = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] CFG_TOPICS          = 2'd0;
  localparam logic [1:0] CFG_WORDS           = 2'd1;
  localparam logic [1:0] CFG_SMOOTHING       = 2'd2;
  localparam logic [1:0] CFG_SMOOTHING_TOTAL = 2'd3;

  localparam logic KIND_NORM = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int COUNT_W   = 31;
  localparam int PROD_HALF = 21;
  localparam int RAWP_W    = 2 * PROD_HALF;
  localparam int PP_W      = COUNT_W + PROD_HALF;
  localparam int DIV_NW    = 72;
  localparam int DIV_DW    = 49;
  localparam int DIV_QW    = 32;
  localparam int DIV_CW    = $clog2(DIV_NW + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX  = 31'h7FFF_FFFF;
  localparam logic [31:0]        PROB_MAX   = 32'hFFFF_FFFF;
  localparam logic [46:0]        TOTAL_MAX  = 47'h7FFF_FFFF_FFFF;
  localparam logic [47:0]        COLSUM_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [DIV_NW-1:0]  RECIP_NUM  = DIV_NW'(1) << 48;
  localparam logic [DIV_DW-1:0]  RECIP_MIN  = DIV_DW'(32'h0001_0000);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              overflow;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/tcpn_divider.sv]
module tcpn_divider (
  input  logic               clk,
  input  logic               rst,
  input  tcpn_pkg::div_req_t req,
  output tcpn_pkg::div_rsp_t rsp
);
  import tcpn_pkg::*;

  logic              busy;
  logic              done;
  logic [DIV_CW-1:0] cnt;
  logic [DIV_NW-1:0] num;
  logic [DIV_DW-1:0] den;
  logic [DIV_DW-1:0] rem;
  logic [DIV_QW-1:0] quo;
  logic              ovf;
  logic [DIV_DW:0]   trial;
  logic              fits;

  always_comb begin
    trial = {rem, num[DIV_NW-1]};
    fits  = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CW'(DIV_NW);
      end else if (busy) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      den <= req.divisor;
      rem <= '0;
      quo <= '0;
      ovf <= 1'b0;
    end else if (busy) begin
      num <= {num[DIV_NW-2:0], 1'b0};
      rem <= fits ? DIV_DW'(trial - {1'b0, den}) : DIV_DW'(trial);
      quo <= {quo[DIV_QW-2:0], fits};
      ovf <= ovf | quo[DIV_QW-1];
    end
  end

  assign rsp.done     = done;
  assign rsp.overflow = ovf;
  assign rsp.quotient = quo;

endmodule

[hdl/topic_count_projection_normalize_core.sv]
// Word-by-topic count projection and column normalization.
// Input channel (in_valid/in_ready) carries one command item: load an entry,
// normalize the columns, or read an entry. Output channel (out_valid/out_ready)
// carries one result item for each normalize and each read; loads give none.
// The block works on one item at a time and takes a new item only when idle.
// A load that is not the last topic of a row only writes the row buffer. The
// last load of a row starts a projection: the row is summed, then each topic
// entry is worked out, with the shared one-bit-per-cycle divider (72 steps)
// where a division is needed. A normalize handles the topics one by one,
// again with the divider. A read passes through S_RD_X, S_RD_MUL and S_RD_SUM.
// A result waits in the output register while the receiver stalls; a next
// result then waits in S_OUT, and the block accepts nothing new.
// Reset (rst, synchronous) clears the column sums and reciprocals through
// their valid bits and restores the configuration registers to defaults.
// Configuration is written through cfg_write_en, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
module topic_count_projection_normalize_core #(
  parameter int TOPICS_MAX = 64,
  parameter int WORDS_MAX  = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [11:0] word_index,
  input  logic [5:0]  topic_index,
  input  logic [31:0] count_value,
  input  logic [23:0] word_doc_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [30:0] adjusted_count,
  output logic [31:0] topic_probability,
  output logic [46:0] total_count
);
  import tcpn_pkg::*;

  localparam int TW       = $clog2(TOPICS_MAX);
  localparam int KW       = $clog2(TOPICS_MAX + 1);
  localparam int WW       = $clog2(WORDS_MAX);
  localparam int WCW      = $clog2(WORDS_MAX + 1);
  localparam int CS_AW    = WW + TW;
  localparam int CS_DEPTH = WORDS_MAX * (2 ** TW);
  localparam int RAW_W    = 33 + TW;
  localparam int CL_W     = 32 + TW;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SUM_RD  = 5'd1;
  localparam logic [4:0] S_SUM_ACC = 5'd2;
  localparam logic [4:0] S_SUM_END = 5'd3;
  localparam logic [4:0] S_CON_W   = 5'd4;
  localparam logic [4:0] S_ENT_RD  = 5'd5;
  localparam logic [4:0] S_ENT_DAT = 5'd6;
  localparam logic [4:0] S_MUL1    = 5'd7;
  localparam logic [4:0] S_MUL2    = 5'd8;
  localparam logic [4:0] S_DIV_W   = 5'd9;
  localparam logic [4:0] S_WB      = 5'd10;
  localparam logic [4:0] S_NRM_RD  = 5'd11;
  localparam logic [4:0] S_NRM_DAT = 5'd12;
  localparam logic [4:0] S_NRM_W   = 5'd13;
  localparam logic [4:0] S_NRM_WB  = 5'd14;
  localparam logic [4:0] S_RD_X    = 5'd15;
  localparam logic [4:0] S_RD_MUL  = 5'd16;
  localparam logic [4:0] S_RD_SUM  = 5'd17;
  localparam logic [4:0] S_OUT     = 5'd18;

  logic [6:0]  topics_in_use;
  logic [12:0] words_in_use;
  logic [31:0] smoothing;
  logic [47:0] smoothing_total;

  logic [4:0]    state;
  logic [TW-1:0] idx;
  logic [WW-1:0] word_q;
  logic [23:0]   docs_q;

  logic [KW-1:0]  k_eff;
  logic [WCW-1:0] w_eff;
  logic           in_range;
  logic           load_last;
  logic           idx_last;
  logic           accept;

  logic signed [RAW_W-1:0] raw_sum;
  logic [CL_W-1:0]         clamp_sum;
  logic [RAWP_W-1:0]       raw_pos;
  logic [COUNT_W-1:0]      con_e;
  logic [COUNT_W-1:0]      e_q;
  logic [COUNT_W-1:0]      a_q;
  logic [PP_W-1:0]         p_lo;
  logic [PP_W-1:0]         p_hi;
  logic [31:0]             recip_q;
  logic [46:0]             total_q;
  logic [48:0]             tot_sum;
  logic [48:0]             d_sum;

  logic [32:0] x_q;
  logic [31:0] r_q;
  logic [48:0] ph_q;
  logic [47:0] pl_q;
  logic [49:0] prob_full;

  logic        pend_kind;
  logic [30:0] pend_count;
  logic [31:0] pend_prob;
  logic [46:0] pend_total;

  logic [COUNT_W-1:0] cs_mem [CS_DEPTH];
  logic [COUNT_W-1:0] cs_q;
  logic               cs_re;
  logic               cs_we;
  logic [CS_AW-1:0]   cs_raddr;
  logic [CS_AW-1:0]   cs_waddr;

  logic signed [31:0] rb_mem [TOPICS_MAX];
  logic signed [31:0] rb_q;
  logic               rb_re;
  logic               rb_we;

  logic [47:0]           col_mem [TOPICS_MAX];
  logic [47:0]           col_q;
  logic                  col_vld_q;
  logic [TOPICS_MAX-1:0] col_valid;
  logic                  col_re;
  logic                  col_we;
  logic [47:0]           col_cur;
  logic [48:0]           col_add;
  logic [47:0]           col_new;

  logic [31:0]           rc_mem [TOPICS_MAX];
  logic [31:0]           rc_q;
  logic                  rc_vld_q;
  logic [TOPICS_MAX-1:0] rc_valid;
  logic                  rc_we;

  logic                 div_go;
  logic [DIV_NW-1:0]    div_num;
  logic [DIV_DW-1:0]    div_den;
  div_req_t             div_req;
  div_rsp_t             div_rsp;

  always_comb begin
    if (topics_in_use == '0) begin
      k_eff = KW'(1);
    end else if (32'(topics_in_use) > TOPICS_MAX) begin
      k_eff = KW'(TOPICS_MAX);
    end else begin
      k_eff = KW'(topics_in_use);
    end
    if (words_in_use == '0) begin
      w_eff = WCW'(1);
    end else if (32'(words_in_use) > WORDS_MAX) begin
      w_eff = WCW'(WORDS_MAX);
    end else begin
      w_eff = WCW'(words_in_use);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = (32'(word_index) < 32'(w_eff)) && (32'(topic_index) < 32'(k_eff));
  assign load_last = (32'(topic_index) == 32'(k_eff) - 32'd1);
  assign idx_last  = (32'(idx) == 32'(k_eff) - 32'd1);
  assign raw_pos   = RAWP_W'(raw_sum);

  assign cs_re    = accept && (cmd == CMD_READ) && in_range;
  assign cs_we    = (state == S_WB);
  assign cs_raddr = {WW'(word_index), TW'(topic_index)};
  assign cs_waddr = {word_q, idx};
  assign rb_re    = (state == S_SUM_RD) || (state == S_ENT_RD);
  assign rb_we    = accept && (cmd == CMD_LOAD) && in_range;
  assign col_re   = (state == S_ENT_RD) || (state == S_NRM_RD);
  assign col_we   = (state == S_WB);
  assign rc_we    = (state == S_NRM_WB);

  assign col_cur   = col_vld_q ? col_q : '0;
  assign col_add   = 49'(col_cur) + 49'(e_q);
  assign col_new   = col_add[48] ? COLSUM_MAX : col_add[47:0];
  assign tot_sum   = 49'(total_q) + 49'(col_cur);
  assign d_sum     = 49'(col_cur) + 49'(smoothing_total);
  assign prob_full = 50'(ph_q) + 50'(pl_q[47:16]);

  assign div_req.start    = div_go;
  assign div_req.dividend = div_num;
  assign div_req.divisor  = div_den;

  tcpn_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (cs_we) begin
      cs_mem[cs_waddr] <= e_q;
    end
    if (cs_re) begin
      cs_q <= cs_mem[cs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rb_we) begin
      rb_mem[TW'(topic_index)] <= count_value;
    end
    if (rb_re) begin
      rb_q <= rb_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[idx] <= col_new;
    end
    if (col_re) begin
      col_q <= col_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rc_we) begin
      rc_mem[idx] <= recip_q;
    end
    if (cs_re) begin
      rc_q <= rc_mem[TW'(topic_index)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topics_in_use   <= 7'd64;
      words_in_use    <= 13'd4096;
      smoothing       <= 32'd65536;
      smoothing_total <= 48'd268435456;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TOPICS:          topics_in_use   <= cfg_data[6:0];
        CFG_WORDS:           words_in_use    <= cfg_data[12:0];
        CFG_SMOOTHING:       smoothing       <= cfg_data[31:0];
        CFG_SMOOTHING_TOTAL: smoothing_total <= cfg_data[47:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      div_go    <= 1'b0;
      col_valid <= '0;
      rc_valid  <= '0;
      col_vld_q <= 1'b0;
      rc_vld_q  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (col_re) begin
        col_vld_q <= col_valid[idx];
      end
      if (cs_re) begin
        rc_vld_q <= rc_valid[TW'(topic_index)];
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid         <= 1'b1;
        result_kind       <= pend_kind;
        adjusted_count    <= pend_count;
        topic_probability <= pend_prob;
        total_count       <= pend_total;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd)
              CMD_LOAD: begin
                if (in_range && load_last) begin
                  word_q    <= WW'(word_index);
                  docs_q    <= word_doc_count;
                  idx       <= '0;
                  raw_sum   <= '0;
                  clamp_sum <= '0;
                  state     <= S_SUM_RD;
                end
              end
              CMD_NORM: begin
                idx     <= '0;
                total_q <= '0;
                state   <= S_NRM_RD;
              end
              CMD_READ: begin
                if (in_range) begin
                  state <= S_RD_X;
                end else begin
                  pend_kind  <= KIND_READ;
                  pend_count <= '0;
                  pend_prob  <= '0;
                  pend_total <= '0;
                  state      <= S_OUT;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          raw_sum <= raw_sum + RAW_W'(rb_q);
          if (rb_q > 0) begin
            clamp_sum <= clamp_sum + CL_W'(rb_q[30:0]);
          end
          if (idx_last) begin
            state <= S_SUM_END;
          end else begin
            idx   <= idx + TW'(1);
            state <= S_SUM_RD;
          end
        end
        S_SUM_END: begin
          idx <= '0;
          if (clamp_sum == '0) begin
            div_num <= DIV_NW'(docs_q);
            div_den <= DIV_DW'(k_eff);
            div_go  <= 1'b1;
            state   <= S_CON_W;
          end else begin
            state <= S_ENT_RD;
          end
        end
        S_CON_W: begin
          if (div_rsp.done) begin
            con_e <= (div_rsp.quotient > 32'h7FFF) ? COUNT_MAX
                                                   : {div_rsp.quotient[14:0], 16'h0000};
            state <= S_ENT_RD;
          end
        end
        S_ENT_RD: begin
          state <= S_ENT_DAT;
        end
        S_ENT_DAT: begin
          if (clamp_sum == '0) begin
            e_q   <= con_e;
            state <= S_WB;
          end else if (raw_sum <= 0 || rb_q <= 0) begin
            e_q   <= '0;
            state <= S_WB;
          end else begin
            a_q   <= rb_q[30:0];
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          p_lo  <= a_q * raw_pos[PROD_HALF-1:0];
          p_hi  <= a_q * raw_pos[RAWP_W-1:PROD_HALF];
          state <= S_MUL2;
        end
        S_MUL2: begin
          div_num <= DIV_NW'(p_lo) + (DIV_NW'(p_hi) << PROD_HALF);
          div_den <= DIV_DW'(clamp_sum);
          div_go  <= 1'b1;
          state   <= S_DIV_W;
        end
        S_DIV_W: begin
          if (div_rsp.done) begin
            e_q   <= (div_rsp.overflow || div_rsp.quotient[31]) ? COUNT_MAX
                                                                : div_rsp.quotient[30:0];
            state <= S_WB;
          end
        end
        S_WB: begin
          col_valid[idx] <= 1'b1;
          if (idx_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + TW'(1);
            state <= S_ENT_RD;
          end
        end
        S_NRM_RD: begin
          state <= S_NRM_DAT;
        end
        S_NRM_DAT: begin
          total_q <= (tot_sum > 49'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[46:0];
          if (d_sum <= RECIP_MIN) begin
            recip_q <= PROB_MAX;
            state   <= S_NRM_WB;
          end else begin
            div_num <= RECIP_NUM;
            div_den <= d_sum;
            div_go  <= 1'b1;
            state   <= S_NRM_W;
          end
        end
        S_NRM_W: begin
          if (div_rsp.done) begin
            recip_q <= div_rsp.quotient;
            state   <= S_NRM_WB;
          end
        end
        S_NRM_WB: begin
          rc_valid[idx] <= 1'b1;
          if (idx_last) begin
            col_valid  <= '0;
            pend_kind  <= KIND_NORM;
            pend_count <= '0;
            pend_prob  <= '0;
            pend_total <= total_q;
            state      <= S_OUT;
          end else begin
            idx   <= idx + TW'(1);
            state <= S_NRM_RD;
          end
        end
        S_RD_X: begin
          x_q        <= 33'(cs_q) + 33'(smoothing);
          r_q        <= rc_vld_q ? rc_q : '0;
          pend_count <= cs_q;
          state      <= S_RD_MUL;
        end
        S_RD_MUL: begin
          ph_q  <= x_q[32:16] * r_q;
          pl_q  <= x_q[15:0] * r_q;
          state <= S_RD_SUM;
        end
        S_RD_SUM: begin
          pend_kind  <= KIND_READ;
          pend_prob  <= (prob_full > 50'(PROB_MAX)) ? PROB_MAX : prob_full[31:0];
          pend_total <= '0;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_result_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result appeared outside the output state");

  a_norm_clears_columns: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && result_kind == KIND_NORM) |-> (col_valid == '0))
    else $error("column sums not cleared after normalize");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_CON_W || state == S_DIV_W || state == S_NRM_W))
    else $error("divider finished while no one waits for it");
`endif

endmodule

[sim/tcpn_monitor.sv]
`timescale 1ns / 100ps

module tcpn_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [11:0] word_index,
  input  logic [5:0]  topic_index,
  input  logic [31:0] count_value,
  input  logic [23:0] word_doc_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        result_kind,
  input  logic [30:0] adjusted_count,
  input  logic [31:0] topic_probability,
  input  logic [46:0] total_count,
  output int          fails,
  output int          awaited_count,
  output int          results_seen
);
  import tcpn_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [30:0] count;
    logic [31:0] prob;
    logic [46:0] total;
  } result_t;

  logic [31:0] count_store [int];
  logic [31:0] row_buf [64];
  logic [47:0] col_sum [64];
  logic [31:0] recip [64];
  logic [6:0]  topics_reg;
  logic [12:0] words_reg;
  logic [31:0] beta;
  logic [47:0] beta_total;
  result_t     awaited [$];

  function automatic int active_topics();
    return (topics_reg == 0) ? 1 : ((topics_reg > 64) ? 64 : int'(topics_reg));
  endfunction

  function automatic int active_words();
    return (words_reg == 0) ? 1 : ((words_reg > 4096) ? 4096 : int'(words_reg));
  endfunction

  function automatic logic [31:0] rescale(logic [31:0] a, logic [47:0] raw,
                                          logic [47:0] clamped);
    logic [127:0] q;
    q = ({96'd0, a} * {80'd0, raw}) / {80'd0, clamped};
    return (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  task automatic project_row(int word, logic [23:0] docs);
    int k_n;
    longint raw;
    longint v;
    longint unsigned clamped;
    longint unsigned con;
    logic [31:0] e;
    logic [48:0] s;
    k_n = active_topics();
    raw = 0;
    clamped = 0;
    for (int k = 0; k < k_n; k++) begin
      v = longint'($signed(row_buf[k]));
      raw += v;
      if (v > 0) clamped += v;
    end
    for (int k = 0; k < k_n; k++) begin
      v = longint'($signed(row_buf[k]));
      if (clamped == 0) begin
        con = docs / k_n;
        e = (con > 32'h7FFF) ? 32'h7FFF_FFFF : 32'(con << 16);
      end else if (raw <= 0) begin
        e = 0;
      end else begin
        e = (v > 0) ? rescale(row_buf[k], raw[47:0], clamped[47:0]) : 32'd0;
      end
      count_store[word * 64 + k] = e;
      s = {1'b0, col_sum[k]} + e;
      col_sum[k] = (s > COLSUM_MAX) ? COLSUM_MAX : s[47:0];
    end
  endtask

  function automatic result_t normalize_columns();
    result_t r;
    logic [48:0] d;
    logic [48:0] q;
    longint unsigned total;
    total = 0;
    for (int k = 0; k < active_topics(); k++) begin
      d = {1'b0, col_sum[k]} + beta_total;
      total += col_sum[k];
      if (total > TOTAL_MAX) total = TOTAL_MAX;
      q = 49'h1_0000_0000_0000 / d;
      recip[k] = (d <= 49'h1_0000) ? PROB_MAX : q[31:0];
    end
    for (int k = 0; k < 64; k++) col_sum[k] = 0;
    r.kind = KIND_NORM;
    r.count = 0;
    r.prob = 0;
    r.total = total[46:0];
    return r;
  endfunction

  function automatic result_t read_probability(int word, int topic);
    result_t r;
    longint unsigned x;
    longint unsigned p;
    longint unsigned rc;
    r = '0;
    r.kind = KIND_READ;
    if (word < active_words() && topic < active_topics()) begin
      if (count_store.exists(word * 64 + topic))
        r.count = count_store[word * 64 + topic][30:0];
      x = r.count + beta;
      rc = recip[topic];
      p = (x >> 16) * rc + (((x & 64'hFFFF) * rc) >> 16);
      r.prob = (p > 64'hFFFF_FFFF) ? PROB_MAX : p[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned exp);
    if (fails < 30)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, exp);
    fails++;
  endtask

  initial begin
    fails = 0;
    awaited_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    result_t exp;
    if (rst) begin
      count_store.delete();
      for (int k = 0; k < 64; k++) begin
        row_buf[k] = 0;
        col_sum[k] = 0;
        recip[k] = 0;
      end
      topics_reg = 7'd64;
      words_reg = 13'd4096;
      beta = 32'd65536;
      beta_total = 48'd268435456;
      awaited.delete();
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_TOPICS:          topics_reg = cfg_data[6:0];
          CFG_WORDS:           words_reg = cfg_data[12:0];
          CFG_SMOOTHING:       beta = cfg_data[31:0];
          CFG_SMOOTHING_TOTAL: beta_total = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (cmd)
          CMD_LOAD: begin
            if (word_index < active_words() && topic_index < active_topics()) begin
              row_buf[topic_index] = count_value;
              if (topic_index == active_topics() - 1) project_row(word_index, word_doc_count);
            end
          end
          CMD_NORM: awaited.push_back(normalize_columns());
          CMD_READ: awaited.push_back(read_probability(word_index, topic_index));
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (awaited.size() == 0) begin
          report_mismatch("unexpected result item", result_kind, 0);
        end else begin
          exp = awaited.pop_front();
          if (result_kind !== exp.kind) report_mismatch("result_kind", result_kind, exp.kind);
          if (adjusted_count !== exp.count)
            report_mismatch("adjusted_count", adjusted_count, exp.count);
          if (topic_probability !== exp.prob)
            report_mismatch("topic_probability", topic_probability, exp.prob);
          if (total_count !== exp.total) report_mismatch("total_count", total_count, exp.total);
        end
      end
    end
    awaited_count = awaited.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tcpn_pkg::*;

  localparam int IDLE_LIMIT = 25000;
  localparam int SETTLE_CYCLES = 6000;

  logic        clk;
  logic        rst;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  cmd;
  logic [11:0] word_index;
  logic [5:0]  topic_index;
  logic [31:0] count_value;
  logic [23:0] word_doc_count;
  logic        out_valid;
  logic        out_ready;
  logic        result_kind;
  logic [30:0] adjusted_count;
  logic [31:0] topic_probability;
  logic [46:0] total_count;

  int fails;
  int awaited_count;
  int results_seen;

  topic_count_projection_normalize_core u_top (.*);

  tcpn_monitor u_mon (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver: changing stall pattern, plus one long hold-off on request.
  logic hold_req;
  bit   hold_taken;
  int   hold_left;
  int   pattern_left;
  int   pattern;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
      pattern_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1;
      hold_left = 2000;
      out_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern = $urandom_range(0, 2);
        pattern_left = $urandom_range(50, 600);
      end
      pattern_left--;
      case (pattern)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  int idle_cycles;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
      $display("** topic_count_projection_normalize_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus-side view of what the block holds, so that no unwritten entry is read.
  int   topics_now;
  int   words_now;
  bit   buf_written [64];
  bit   entry_written [int];
  int   written_keys [$];
  int   sent;
  int   burst_left;

  task automatic write_config(logic [6:0] k, logic [12:0] w, logic [31:0] b, logic [47:0] bt);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_TOPICS;
    cfg_data <= 48'(k);
    @(posedge clk);
    cfg_index <= CFG_WORDS;
    cfg_data <= 48'(w);
    @(posedge clk);
    cfg_index <= CFG_SMOOTHING;
    cfg_data <= 48'(b);
    @(posedge clk);
    cfg_index <= CFG_SMOOTHING_TOTAL;
    cfg_data <= bt;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    topics_now = (k == 0) ? 1 : ((k > 64) ? 64 : int'(k));
    words_now = (w == 0) ? 1 : ((w > 4096) ? 4096 : int'(w));
  endtask

  task automatic wait_drained();
    while (awaited_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] c, int word, int topic, logic [31:0] v, logic [23:0] d);
    int key;
    in_valid <= 1'b1;
    cmd <= c;
    word_index <= 12'(word);
    topic_index <= 6'(topic);
    count_value <= v;
    word_doc_count <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    if (c == CMD_LOAD && word < words_now && topic < topics_now) begin
      buf_written[topic] = 1;
      if (topic == topics_now - 1) begin
        for (int k = 0; k < topics_now; k++) begin
          key = word * 64 + k;
          if (!entry_written.exists(key)) begin
            entry_written[key] = 1;
            written_keys.push_back(key);
          end
        end
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5))
        @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 12);
    end
  endtask

  function automatic logic [31:0] pick_count(int style);
    case (style)
      0: return $urandom;
      1: return $urandom_range(0, 400000) - 100000;
      2: return ($urandom_range(0, 2) == 0) ? 32'd0 : -$urandom_range(1, 32'h7FFF_FFFF);
      default: return -$urandom_range(1000000, 5000000);
    endcase
  endfunction

  task automatic send_row(int word);
    int style;
    logic [23:0] docs;
    logic [31:0] v;
    style = $urandom_range(0, 5);
    if (style > 3) style = 1;
    case ($urandom_range(0, 3))
      0: docs = 24'd0;
      1: docs = 24'hFFFFFF;
      2: docs = $urandom_range(0, 5000);
      default: docs = $urandom;
    endcase
    for (int t = 0; t < topics_now; t++) begin
      v = pick_count(style);
      // A lone small positive keeps the raw sum at or below zero.
      if (style == 3 && t == topics_now - 1) v = $urandom_range(1, 1000);
      send_item(CMD_LOAD, word, t, v, docs);
    end
  endtask

  function automatic bit row_buffer_full();
    for (int k = 0; k < topics_now - 1; k++) if (!buf_written[k]) return 0;
    return 1;
  endfunction

  task automatic random_traffic(int n);
    int start;
    int r;
    int word;
    int topic;
    int key;
    start = sent;
    while (sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_row($urandom_range(0, words_now - 1));
      end else if (r < 78) begin
        if (written_keys.size() != 0) begin
          key = written_keys[$urandom_range(0, written_keys.size() - 1)];
          send_item(CMD_READ, key / 64, key % 64, $urandom, $urandom);
        end
      end else if (r < 84) begin
        if (words_now < 4096) begin
          send_item(CMD_READ, $urandom_range(words_now, 4095), $urandom_range(0, 63),
                    $urandom, $urandom);
        end else if (topics_now < 64) begin
          send_item(CMD_READ, $urandom_range(0, 4095), $urandom_range(topics_now, 63),
                    $urandom, $urandom);
        end
      end else if (r < 90) begin
        send_item(CMD_NORM, $urandom_range(0, 4095), $urandom_range(0, 63), $urandom, $urandom);
      end else if (r < 94) begin
        send_item(2'd3, $urandom_range(0, 4095), $urandom_range(0, 63), $urandom, $urandom);
      end else begin
        word = $urandom_range(0, 4095);
        topic = $urandom_range(0, 63);
        if (word < words_now && topic == topics_now - 1 && !row_buffer_full())
          topic = (topics_now > 1) ? 0 : 1;
        if (!(word < words_now && topic == 0 && topics_now == 1))
          send_item(CMD_LOAD, word, topic, $urandom, $urandom);
      end
    end
  endtask

  logic [6:0]  phase_topics [8] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd16, 7'd3, 7'd64};
  logic [12:0] phase_words [8] = '{13'd4096, 13'd16, 13'd0, 13'd8191, 13'd100, 13'd4096,
                                   13'd1, 13'd200};
  logic [31:0] phase_beta [8] = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd12345678, 32'd1,
                                  32'h8000_0000, 32'd65536, 32'h0003_1415};
  logic [47:0] phase_beta_total [8] = '{48'd268435456, 48'hFFFF_FFFF_FFFF, 48'd65536, 48'd1,
                                        48'd0, 48'd10000000, 48'h0123_4567_89AB, 48'd65537};

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = CFG_TOPICS;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_LOAD;
    word_index = '0;
    topic_index = '0;
    count_value = '0;
    word_doc_count = '0;
    hold_req = 1'b0;
    sent = 0;
    burst_left = 0;
    topics_now = 64;
    words_now = 4096;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: two-topic rows covering the extremes and each projection case.
    write_config(7'd2, 13'd16, 32'd0, 48'd0);
    send_item(CMD_LOAD, 3, 0, 32'h7FFF_FFFF, 24'd0);
    send_item(CMD_LOAD, 3, 1, 32'h7FFF_FFFF, 24'd0);
    send_item(CMD_LOAD, 15, 0, 32'h8000_0000, 24'hFFFFFF);
    send_item(CMD_LOAD, 15, 1, 32'd0, 24'hFFFFFF);
    send_item(CMD_LOAD, 0, 0, -32'd500000, 24'd9);
    send_item(CMD_LOAD, 0, 1, 32'd3, 24'd9);
    send_item(CMD_LOAD, 7, 0, 32'd0, 24'd5);
    send_item(CMD_LOAD, 7, 1, 32'd0, 24'd5);
    send_item(CMD_LOAD, 4, 0, 32'd1, 24'd0);
    send_item(CMD_LOAD, 4, 1, 32'h7FFF_FFFF, 24'd0);
    send_item(CMD_LOAD, 20, 1, 32'd77, 24'd1);
    send_item(CMD_LOAD, 5, 2, 32'd77, 24'd1);
    send_item(2'd3, 4095, 63, 32'hFFFF_FFFF, 24'hFFFFFF);
    send_item(CMD_READ, 3, 0, 32'd0, 24'd0);
    send_item(CMD_NORM, 0, 0, 32'd0, 24'd0);
    send_item(CMD_READ, 3, 1, 32'd0, 24'd0);
    send_item(CMD_READ, 15, 0, 32'd0, 24'd0);
    send_item(CMD_READ, 0, 1, 32'd0, 24'd0);
    send_item(CMD_READ, 7, 0, 32'd0, 24'd0);
    send_item(CMD_READ, 4, 1, 32'd0, 24'd0);
    send_item(CMD_READ, 16, 0, 32'd0, 24'd0);
    send_item(CMD_READ, 4095, 63, 32'd0, 24'd0);
    send_item(CMD_NORM, 0, 0, 32'd0, 24'd0);
    send_item(CMD_READ, 4, 0, 32'd0, 24'd0);
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      write_config(phase_topics[p], phase_words[p], phase_beta[p], phase_beta_total[p]);
      if (p == 1) hold_req <= 1'b1;
      random_traffic(175);
      send_item(CMD_NORM, 0, 0, 32'd0, 24'd0);
      random_traffic(3);
      in_valid <= 1'b0;
      wait_drained();
    end

    $display("Sent %0d input items over nine register settings; %0d result items checked.",
             sent, results_seen);
    if (fails == 0) begin
      $display("** topic_count_projection_normalize_core: PASSED **");
    end else begin
      $display("%0d mismatches found.", fails);
      $display("** topic_count_projection_normalize_core: FAILED **");
    end
    $finish;
  end

endmodule
